>>> rtl/c3lf_pkg.sv
// Shared widths, register indexes and types of the 3x3 line filter.
`default_nettype none

package c3lf_pkg;

  // Field and datapath widths
  localparam int PIX_W   = 8;
  localparam int TAP_W   = 8;
  localparam int COL_W   = 3 * PIX_W;
  localparam int TAPS_W  = 3 * TAP_W;
  localparam int ACC_W   = 20;
  localparam int CFG_IDX_W = 2;

  // Right shift applied to the accumulated sum before clamping
  localparam int OUT_SHIFT = 4;

  // Largest output pixel value
  localparam logic [PIX_W-1:0] PIX_MAX = '1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TAPS_TOP = 2'd0,
    REG_TAPS_MID = 2'd1,
    REG_TAPS_BOT = 2'd2
  } cfg_reg_t;

  // One pending filter job: left, center and right columns plus end mark
  typedef struct packed {
    logic [COL_W-1:0] col_l;
    logic [COL_W-1:0] col_c;
    logic [COL_W-1:0] col_r;
    logic             line_end;
  } job_t;

endpackage

`default_nettype wire

>>> rtl/conv3x3_line_filter_unit.sv
// 3x3 line filter over a column stream with replicated left and right borders.
`default_nettype none

// Each transfer on the slave side carries one image column (three pixels of
// adjacent lines). The unit keeps the two previous columns and emits one
// filtered pixel per column, one column late; the last column of a line emits
// a second pixel with m_tlast set, and a column with the first flag restarts
// the window, dropping any column still pending. The nine 8x8 products, the
// sum, the floor shift and the clamp sit in one stage between the job
// register and the output register. A column is taken every clock while the
// output is not stalled; a column that closes a line (and is not the only
// column) yields two results, which leave through the single output register
// one after the other and hold off the next column. The user must write taps
// through the cfg port only while the unit is idle; the unit itself does not
// enforce this.
module conv3x3_line_filter_unit #(
  parameter int OUT_SHIFT = c3lf_pkg::OUT_SHIFT
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // column stream
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  input  wire logic [c3lf_pkg::COL_W-1:0]     s_tdata,  // pixel_top, pixel_mid, pixel_bot
  input  wire logic                           s_tuser,  // first_col
  input  wire logic                           s_tlast,  // last_col
  // filtered pixel stream
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  output logic [c3lf_pkg::PIX_W-1:0]          m_tdata,  // pixel_out
  output logic                                m_tlast,  // line_end
  // tap configuration
  input  wire logic                           cfg_we,
  input  wire logic [c3lf_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [c3lf_pkg::TAPS_W-1:0]    cfg_data
);

  localparam int PW = c3lf_pkg::PIX_W;
  localparam int AW = c3lf_pkg::ACC_W;

  // Multiply-accumulate one line: three pixels against three signed taps
  function automatic logic signed [AW-1:0] row_mac(
    input logic [c3lf_pkg::TAPS_W-1:0] taps,
    input logic [PW-1:0]               pa,
    input logic [PW-1:0]               pb,
    input logic [PW-1:0]               pc
  );
    logic signed [AW-1:0] ea, eb, ec;
    logic signed [AW-1:0] ta, tb, tc;
    logic signed [AW-1:0] sum;
    ea  = $signed({{(AW-PW){1'b0}}, pa});
    eb  = $signed({{(AW-PW){1'b0}}, pb});
    ec  = $signed({{(AW-PW){1'b0}}, pc});
    ta  = $signed({{(AW-c3lf_pkg::TAP_W){taps[7]}},  taps[7:0]});
    tb  = $signed({{(AW-c3lf_pkg::TAP_W){taps[15]}}, taps[15:8]});
    tc  = $signed({{(AW-c3lf_pkg::TAP_W){taps[23]}}, taps[23:16]});
    sum = ea * ta + eb * tb + ec * tc;
    return sum;
  endfunction

  // Tap registers
  logic [c3lf_pkg::TAPS_W-1:0] taps_top, taps_mid, taps_bot;

  // Column window state
  logic [c3lf_pkg::COL_W-1:0] left_col, center_col;
  logic                       have_center;

  // Job register (up to two jobs from one column) and output register
  c3lf_pkg::job_t jobs [2];
  logic [1:0]     job_cnt;
  logic [1:0]     job_cnt_next;
  logic           out_valid;
  logic [PW-1:0]  out_pix;
  logic           out_end;

  logic           accept, out_adv, drain, start;
  logic [c3lf_pkg::COL_W-1:0] next_left;
  c3lf_pkg::job_t job_a, job_b;
  logic [1:0]     new_jobs;

  logic signed [AW-1:0] acc_sum, acc_shr;
  logic [PW-1:0]        filt_pix;

  // Handshake: take a column once the job register will be empty
  assign out_adv  = !out_valid || m_tready;
  assign drain    = (job_cnt != 2'd0) && out_adv;
  assign s_tready = (job_cnt == 2'd0) || ((job_cnt == 2'd1) && out_adv);
  assign accept   = s_tvalid && s_tready;

  // Build the jobs a column produces
  assign start     = s_tuser || !have_center;
  assign next_left = start ? s_tdata : center_col;
  assign job_a     = '{col_l: left_col, col_c: center_col, col_r: s_tdata, line_end: 1'b0};
  assign job_b     = '{col_l: next_left, col_c: s_tdata, col_r: s_tdata, line_end: 1'b1};
  assign new_jobs  = {!start && s_tlast, (!start) ^ s_tlast};

  always_comb begin
    job_cnt_next = job_cnt;
    if (drain) begin
      job_cnt_next = job_cnt - 2'd1;
    end
    if (accept) begin
      job_cnt_next = new_jobs;
    end
  end

  // Filter the head job: nine products, floor shift, clamp
  assign acc_sum = row_mac(taps_top, jobs[0].col_l[7:0], jobs[0].col_c[7:0],
                           jobs[0].col_r[7:0])
                 + row_mac(taps_mid, jobs[0].col_l[15:8], jobs[0].col_c[15:8],
                           jobs[0].col_r[15:8])
                 + row_mac(taps_bot, jobs[0].col_l[23:16], jobs[0].col_c[23:16],
                           jobs[0].col_r[23:16]);
  assign acc_shr = acc_sum >>> OUT_SHIFT;

  always_comb begin
    if (acc_shr < 0) begin
      filt_pix = '0;
    end else if (acc_shr > $signed({{(AW-PW){1'b0}}, c3lf_pkg::PIX_MAX})) begin
      filt_pix = c3lf_pkg::PIX_MAX;
    end else begin
      filt_pix = acc_shr[PW-1:0];
    end
  end

  // Write tap registers
  always_ff @(posedge clk) begin
    if (rst) begin
      taps_top <= '0;
      taps_mid <= '0;
      taps_bot <= '0;
    end else if (cfg_we) begin
      case (c3lf_pkg::cfg_reg_t'(cfg_idx))
        c3lf_pkg::REG_TAPS_TOP: taps_top <= cfg_data;
        c3lf_pkg::REG_TAPS_MID: taps_mid <= cfg_data;
        c3lf_pkg::REG_TAPS_BOT: taps_bot <= cfg_data;
        default: ;
      endcase
    end
  end

  // Advance the column window on each input transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      left_col    <= '0;
      center_col  <= '0;
      have_center <= 1'b0;
    end else if (accept) begin
      left_col    <= next_left;
      center_col  <= s_tdata;
      have_center <= !s_tlast;
    end
  end

  // Control of job and output registers
  always_ff @(posedge clk) begin
    if (rst) begin
      job_cnt   <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      job_cnt <= job_cnt_next;
      if (out_adv) begin
        out_valid <= drain;
      end
    end
  end

  // Load or shift job slots
  always_ff @(posedge clk) begin
    if (accept) begin
      if (!start) begin
        jobs[0] <= job_a;
        jobs[1] <= job_b;
      end else begin
        jobs[0] <= job_b;
      end
    end else if (drain) begin
      jobs[0] <= jobs[1];
    end
  end

  // Hold result until its transfer
  always_ff @(posedge clk) begin
    if (drain) begin
      out_pix <= filt_pix;
      out_end <= jobs[0].line_end;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_pix;
  assign m_tlast  = out_end;

  // A full job register must block the column stream
  a_full_blocks: assert property (@(posedge clk) disable iff (rst)
    (job_cnt == 2'd2) |-> !s_tready)
    else $error("column taken while two jobs pending");

  // An interior last column queues two jobs
  a_last_two_jobs: assert property (@(posedge clk) disable iff (rst)
    (accept && s_tlast && !start) |=> (job_cnt == 2'd2))
    else $error("last column did not queue two jobs");

  // A line end leaves nothing pending
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && s_tlast) |=> !have_center)
    else $error("column still pending after line end");

  // A column that opens a line without closing it yields no job
  a_first_no_job: assert property (@(posedge clk) disable iff (rst)
    (accept && start && !s_tlast) |=> (job_cnt == 2'd0))
    else $error("first column produced a job");

endmodule

`default_nettype wire

>>> bench/conv3x3_line_filter_unit_test.sv
// Self-checking testbench for the 3x3 column-stream line filter.
`timescale 1ns / 100ps

module conv3x3_line_filter_unit_test;

  localparam int CYCLE_LIMIT = 500000;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_COLUMNS = 165;
  localparam int RANDOM_PHASES = 10;

  // One column as the sender sees it
  typedef struct packed {
    logic                       first;
    logic                       last;
    logic [c3lf_pkg::PIX_W-1:0] bot;
    logic [c3lf_pkg::PIX_W-1:0] mid;
    logic [c3lf_pkg::PIX_W-1:0] top;
  } column_t;

  // One filtered pixel as the receiver sees it
  typedef struct packed {
    logic [c3lf_pkg::PIX_W-1:0] pixel;
    logic                       line_end;
  } out_pixel_t;

  // Window predictor and queue of pixels still owed by the unit
  class pixel_board;
    logic [c3lf_pkg::TAPS_W-1:0] row_taps [3];
    logic [c3lf_pkg::COL_W-1:0] left_col;
    logic [c3lf_pkg::COL_W-1:0] center_col;
    bit pending;
    out_pixel_t expected_pixels[$];
    int errors;

    function new();
      foreach (row_taps[i]) row_taps[i] = '0;
      left_col = '0;
      center_col = '0;
      pending = 1'b0;
      errors = 0;
    endfunction

    function void set_taps(logic [c3lf_pkg::TAPS_W-1:0] top,
                           logic [c3lf_pkg::TAPS_W-1:0] mid,
                           logic [c3lf_pkg::TAPS_W-1:0] bot);
      row_taps[0] = top;
      row_taps[1] = mid;
      row_taps[2] = bot;
    endfunction

    // Nine signed products, floor shift, clamp to a byte
    function logic [c3lf_pkg::PIX_W-1:0] filter_window(logic [c3lf_pkg::COL_W-1:0] l,
                                                       logic [c3lf_pkg::COL_W-1:0] c,
                                                       logic [c3lf_pkg::COL_W-1:0] r);
      int acc;
      int q;
      int tap_v;
      int pix_v;
      logic [c3lf_pkg::COL_W-1:0] win [3];
      win[0] = l;
      win[1] = c;
      win[2] = r;
      acc = 0;
      for (int ln = 0; ln < 3; ln++) begin
        for (int k = 0; k < 3; k++) begin
          tap_v = $signed(row_taps[ln][8*k +: 8]);
          pix_v = win[k][8*ln +: 8];
          acc += tap_v * pix_v;
        end
      end
      q = acc >>> c3lf_pkg::OUT_SHIFT;
      if (q < 0) q = 0;
      if (q > 255) q = 255;
      return q[c3lf_pkg::PIX_W-1:0];
    endfunction

    // Advance the window on an accepted column and queue what it yields
    function void note_column(column_t c);
      logic [c3lf_pkg::COL_W-1:0] col;
      out_pixel_t owed;
      col = {c.bot, c.mid, c.top};
      if (c.first || !pending) begin
        left_col = col;
        center_col = col;
        pending = 1'b1;
      end else begin
        owed.pixel = filter_window(left_col, center_col, col);
        owed.line_end = 1'b0;
        expected_pixels.push_back(owed);
        left_col = center_col;
        center_col = col;
      end
      // right border: replicate the last column
      if (c.last) begin
        owed.pixel = filter_window(left_col, center_col, center_col);
        owed.line_end = 1'b1;
        expected_pixels.push_back(owed);
        pending = 1'b0;
      end
    endfunction

    // Compare a transferred pixel with the oldest one owed
    function void check_pixel(logic [c3lf_pkg::PIX_W-1:0] pixel, logic line_end);
      out_pixel_t owed;
      if (expected_pixels.size() == 0) begin
        errors++;
        $display("%0t: unexpected pixel: expected none, actual pixel %0d line_end %0b",
                 $time, pixel, line_end);
        return;
      end
      owed = expected_pixels.pop_front();
      if (pixel !== owed.pixel) begin
        errors++;
        $display("%0t: pixel mismatch: expected %0d, actual %0d",
                 $time, owed.pixel, pixel);
      end
      if (line_end !== owed.line_end) begin
        errors++;
        $display("%0t: line_end mismatch: expected %0b, actual %0b",
                 $time, owed.line_end, line_end);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [c3lf_pkg::COL_W-1:0] s_tdata = '0;  // pixel_top, pixel_mid, pixel_bot
  logic s_tuser = 1'b0;                      // first_col
  logic s_tlast = 1'b0;                      // last_col
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [c3lf_pkg::PIX_W-1:0] m_tdata;       // pixel_out
  logic m_tlast;                             // line_end
  logic cfg_we = 1'b0;
  logic [c3lf_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
  logic [c3lf_pkg::TAPS_W-1:0] cfg_data = '0;

  pixel_board board;
  int burst_left = 0;
  int cycle_count = 0;
  int ready_tick = 0;
  int ready_mode = 0;

  conv3x3_line_filter_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  // Stall the receiver with one of four patterns, chosen at random
  always @(posedge clk) begin
    ready_tick <= ready_tick + 1;
    if (ready_tick % 256 == 0) ready_mode <= $urandom_range(0, 3);
    case (ready_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= 1'($urandom_range(0, 1));
      2: m_tready <= (ready_tick % 5 != 3);
      default: m_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // Check every output transfer
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_pixel(m_tdata, m_tlast);
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("conv3x3_line_filter_unit_test: errors");
      $finish;
    end
  end

  function automatic column_t make_column(logic [7:0] top, logic [7:0] mid, logic [7:0] bot,
                                          logic first, logic last);
    column_t c;
    c.top = top;
    c.mid = mid;
    c.bot = bot;
    c.first = first;
    c.last = last;
    return c;
  endfunction

  // Lean toward the extremes now and then
  function automatic logic [7:0] rand_pixel();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [c3lf_pkg::TAPS_W-1:0] small_taps();
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    b0 = 8'($urandom_range(0, 16) - 8);
    b1 = 8'($urandom_range(0, 16) - 8);
    b2 = 8'($urandom_range(0, 16) - 8);
    return {b2, b1, b0};
  endfunction

  // Write all three tap rows; the unit is idle here
  task automatic write_taps(logic [c3lf_pkg::TAPS_W-1:0] top,
                            logic [c3lf_pkg::TAPS_W-1:0] mid,
                            logic [c3lf_pkg::TAPS_W-1:0] bot);
    cfg_we <= 1'b1;
    cfg_idx <= c3lf_pkg::REG_TAPS_TOP;
    cfg_data <= top;
    @(posedge clk);
    cfg_idx <= c3lf_pkg::REG_TAPS_MID;
    cfg_data <= mid;
    @(posedge clk);
    cfg_idx <= c3lf_pkg::REG_TAPS_BOT;
    cfg_data <= bot;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.set_taps(top, mid, bot);
  endtask

  // Send one column in bursts with random gaps between them
  task automatic push_column(column_t c);
    int gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 1) == 0) gap = 0;
      else if ($urandom_range(0, 9) == 0) gap = $urandom_range(10, 20);
      else gap = $urandom_range(1, 5);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {c.bot, c.mid, c.top};
    s_tuser <= c.first;
    s_tlast <= c.last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.note_column(c);
    burst_left--;
  endtask

  // Drop valid, wait for every owed pixel, then let the pipeline settle
  task automatic finish_phase();
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (board.expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly whole lines, some cut short, some with stray flags
  task automatic random_lines(int quota);
    int sent;
    int kind;
    int len;
    sent = 0;
    while (sent < quota) begin
      kind = $urandom_range(0, 9);
      if (kind <= 6) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 48) : $urandom_range(1, 10);
        for (int i = 0; i < len; i++)
          push_column(make_column(rand_pixel(), rand_pixel(), rand_pixel(),
                                  i == 0, i == len - 1));
      end else if (kind == 7) begin
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++)
          push_column(make_column(rand_pixel(), rand_pixel(), rand_pixel(), i == 0, 1'b0));
      end else begin
        len = $urandom_range(1, 4);
        for (int i = 0; i < len; i++)
          push_column(make_column(rand_pixel(), rand_pixel(), rand_pixel(),
                                  $urandom_range(0, 3) == 0, $urandom_range(0, 2) == 0));
      end
      sent += len;
    end
  endtask

  initial begin
    logic [c3lf_pkg::TAPS_W-1:0] tt;
    logic [c3lf_pkg::TAPS_W-1:0] tm;
    logic [c3lf_pkg::TAPS_W-1:0] tb;
    board = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: borders, restarts, one- and two-column lines, pixel extremes
    write_taps(24'h107F80, 24'hFF4001, 24'h00807F);
    push_column(make_column(8'hFF, 8'h00, 8'hFF, 1'b0, 1'b0));
    push_column(make_column(8'h00, 8'hFF, 8'h00, 1'b0, 1'b0));
    push_column(make_column(8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b1));
    push_column(make_column(8'h00, 8'h00, 8'h00, 1'b1, 1'b1));
    push_column(make_column(8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1));
    push_column(make_column(8'h12, 8'h34, 8'h56, 1'b1, 1'b0));
    push_column(make_column(8'h80, 8'h7F, 8'h01, 1'b1, 1'b0));
    push_column(make_column(8'hFE, 8'h01, 8'h80, 1'b0, 1'b0));
    push_column(make_column(8'hFF, 8'h00, 8'h00, 1'b0, 1'b0));
    push_column(make_column(8'h00, 8'hFF, 8'h00, 1'b1, 1'b0));
    push_column(make_column(8'h00, 8'h00, 8'hFF, 1'b0, 1'b1));
    push_column(make_column(8'h55, 8'hAA, 8'h55, 1'b0, 1'b1));
    push_column(make_column(8'hAA, 8'h55, 8'hAA, 1'b1, 1'b0));
    push_column(make_column(8'h01, 8'h02, 8'h04, 1'b0, 1'b0));
    push_column(make_column(8'h08, 8'h10, 8'h20, 1'b0, 1'b0));
    push_column(make_column(8'h40, 8'h80, 8'hFF, 1'b0, 1'b1));
    finish_phase();

    // Random traffic under a series of tap settings
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: begin tt = 24'h7F7F7F; tm = 24'h7F7F7F; tb = 24'h7F7F7F; end
        1: begin tt = 24'h808080; tm = 24'h808080; tb = 24'h808080; end
        2: begin tt = 24'h000000; tm = 24'h001000; tb = 24'h000000; end
        3: begin tt = 24'h000000; tm = 24'h000000; tb = 24'h000000; end
        4: begin tt = 24'h010201; tm = 24'h020402; tb = 24'h010201; end
        5: begin tt = 24'h00FF00; tm = 24'hFF08FF; tb = 24'h00FF00; end
        6, 7: begin tt = small_taps(); tm = small_taps(); tb = small_taps(); end
        default: begin
          tt = 24'($urandom_range(0, 24'hFFFFFF));
          tm = 24'($urandom_range(0, 24'hFFFFFF));
          tb = 24'($urandom_range(0, 24'hFFFFFF));
        end
      endcase
      write_taps(tt, tm, tb);
      random_lines(PHASE_COLUMNS);
      finish_phase();
    end

    if (board.errors == 0 && board.expected_pixels.size() == 0)
      $display("conv3x3_line_filter_unit_test: clean");
    else
      $display("conv3x3_line_filter_unit_test: errors");
    $finish;
  end

endmodule
